>>> sv/u8u16_pkg.sv
package u8u16_pkg;

  localparam int ByteW = 8;
  localparam int UnitW = 16;
  localparam int CountW = 2;
  localparam int PayloadW = 6;

  localparam logic [UnitW-1:0] Replacement = 16'hFFFD;

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_CONT,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_INVALID
  } byte_class_t;

  typedef struct packed {
    logic             valid;
    logic [UnitW-1:0] unit;
    logic             err;
    logic             last;
  } result_t;

  function automatic byte_class_t classify(input logic [ByteW-1:0] b);
    byte_class_t cls;
    if (b[7] == 1'b0) begin
      cls = CLS_ASCII;
    end else if (b[7:6] == 2'b10) begin
      cls = CLS_CONT;
    end else if (b[7:5] == 3'b110) begin
      cls = CLS_LEAD2;
    end else if (b[7:4] == 4'b1110) begin
      cls = CLS_LEAD3;
    end else if (b[7:3] == 5'b11110) begin
      cls = CLS_LEAD4;
    end else begin
      cls = CLS_INVALID;
    end
    return cls;
  endfunction

endpackage

>>> sv/utf8_to_utf16_unit_decoder.sv
// Channel  Dir  tdata (low bit up)  tuser     tlast
// s_*      in   byte_in[7:0]        -         end_of_string
// m_*      out  code_unit[15:0]     is_error  last_of_run
//
// One byte is taken per cycle while s_tready is high; results land in an output register the next cycle.
// A byte that yields two units (ASCII after an unfinished sequence) parks the
// second unit in a hold register, which closes s_tready until that unit moves to the output register.
// rst clears the pending count, accumulator and both result valids.
// m_tready low stalls the output register and, through it, s_tready.
module utf8_to_utf16_unit_decoder (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [u8u16_pkg::ByteW-1:0]      s_tdata,   // byte_in
  input  logic                             s_tlast,   // end_of_string
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [u8u16_pkg::UnitW-1:0]      m_tdata,   // code_unit
  output logic                             m_tuser,   // is_error
  output logic                             m_tlast    // last_of_run
);
  import u8u16_pkg::*;

  logic [UnitW-1:0]  accumulator;
  logic [UnitW-1:0]  accumulator_next;
  logic [CountW-1:0] pending_count;
  logic [CountW-1:0] pending_count_next;
  result_t           out_reg;
  result_t           hold_reg;
  result_t           res0;
  result_t           res1;
  byte_class_t       cls;
  logic              fire;

  assign s_tready = !hold_reg.valid && (!out_reg.valid || m_tready);
  assign fire     = s_tvalid && s_tready;
  assign cls      = classify(s_tdata);

  always_comb begin
    accumulator_next   = accumulator;
    pending_count_next = pending_count;
    res0 = '0;
    res1 = '0;
    case (cls)
      CLS_ASCII: begin
        if (pending_count != '0) begin
          res0 = '{valid: 1'b1, unit: Replacement, err: 1'b1, last: 1'b0};
          res1 = '{valid: 1'b1, unit: {{(UnitW-ByteW){1'b0}}, s_tdata},
                   err: 1'b0, last: 1'b0};
        end else begin
          res0 = '{valid: 1'b1, unit: {{(UnitW-ByteW){1'b0}}, s_tdata},
                   err: 1'b0, last: 1'b0};
        end
        pending_count_next = '0;
      end
      CLS_CONT: begin
        if (pending_count != '0) begin
          accumulator_next   = {accumulator[UnitW-PayloadW-1:0], s_tdata[PayloadW-1:0]};
          pending_count_next = pending_count - 1'b1;
          if (pending_count_next == '0) begin
            res0 = '{valid: 1'b1, unit: accumulator_next, err: 1'b0, last: 1'b0};
          end
        end else begin
          res0 = '{valid: 1'b1, unit: Replacement, err: 1'b1, last: 1'b0};
        end
      end
      CLS_LEAD2: begin
        pending_count_next = 2'd1;
        accumulator_next   = {{(UnitW-5){1'b0}}, s_tdata[4:0]};
      end
      CLS_LEAD3: begin
        pending_count_next = 2'd2;
        accumulator_next   = {{(UnitW-4){1'b0}}, s_tdata[3:0]};
      end
      CLS_LEAD4: begin
        pending_count_next = 2'd3;
        accumulator_next   = {{(UnitW-3){1'b0}}, s_tdata[2:0]};
      end
      default: begin
        res0 = '{valid: 1'b1, unit: Replacement, err: 1'b1, last: 1'b0};
        pending_count_next = '0;
      end
    endcase

    if (s_tlast) begin
      if (pending_count_next != '0) begin
        if (!res0.valid) begin
          res0 = '{valid: 1'b1, unit: Replacement, err: 1'b1, last: 1'b0};
        end else begin
          res1 = '{valid: 1'b1, unit: Replacement, err: 1'b1, last: 1'b0};
        end
      end
      pending_count_next = '0;
      accumulator_next   = '0;
    end

    if (res1.valid) begin
      res1.last = 1'b1;
    end else begin
      res0.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator    <= '0;
      pending_count  <= '0;
      out_reg.valid  <= 1'b0;
      hold_reg.valid <= 1'b0;
    end else begin
      if (fire) begin
        accumulator   <= accumulator_next;
        pending_count <= pending_count_next;
        if (res0.valid) begin
          out_reg <= res0;
        end else begin
          out_reg.valid <= 1'b0;
        end
        hold_reg <= res1;
      end else if (hold_reg.valid && m_tready) begin
        out_reg        <= hold_reg;
        hold_reg.valid <= 1'b0;
      end else if (m_tready) begin
        out_reg.valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_reg.valid;
  assign m_tdata  = out_reg.unit;
  assign m_tuser  = out_reg.err;
  assign m_tlast  = out_reg.last;

endmodule
